FILE: hw/rtl/ssta_pkg.sv
package ssta_pkg;

	// Default table size and reset value of the stale timeout.
	localparam int          TABLE_DEPTH = 64;
	localparam logic [31:0] TIMEOUT_RST = 32'd30000;
	localparam logic [15:0] HITS_MAX    = 16'hFFFF;

	// Item kinds.
	localparam logic FUNC_OBS   = 1'b0;
	localparam logic FUNC_SWEEP = 1'b1;

	// Result outcome codes.
	localparam logic [1:0] OUT_UPDATE = 2'd0;
	localparam logic [1:0] OUT_INSERT = 2'd1;
	localparam logic [1:0] OUT_DROP   = 2'd2;
	localparam logic [1:0] OUT_SWEEP  = 2'd3;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [47:0]       addr;
		logic [31:0]       first_seen;
		logic [31:0]       last_seen;
		logic [15:0]       hits;
		logic signed [7:0] signal;
		logic [3:0]        channel;
		logic [1:0]        method;
		logic              active;
	} entry_t;

	// Status of one entry after it went through the entry unit.
	typedef struct packed {
		logic match;
		logic active;
	} eval_t;

endpackage

FILE: hw/rtl/ssta_obs_if.sv
interface ssta_obs_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [47:0]       station_addr;
	logic signed [7:0] signal_dbm;
	logic [3:0]        radio_channel;
	logic [1:0]        match_method;
	logic [31:0]       now_ms;

	modport source (output valid, func, station_addr, signal_dbm, radio_channel,
		match_method, now_ms, input ready);
	modport sink (input valid, func, station_addr, signal_dbm, radio_channel,
		match_method, now_ms, output ready);
endinterface

FILE: hw/rtl/ssta_res_if.sv
interface ssta_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [5:0]  slot;
	logic [15:0] hits;
	logic [6:0]  entries_used;
	logic [6:0]  entries_active;

	modport source (output valid, outcome, slot, hits, entries_used, entries_active,
		input ready);
	modport sink (input valid, outcome, slot, hits, entries_used, entries_active,
		output ready);
endinterface

FILE: hw/rtl/ssta_cfg_if.sv
interface ssta_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/ssta_ram.sv
module ssta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/ssta_entry_unit.sv
module ssta_entry_unit (
	input  ssta_pkg::entry_t  entry,
	input  logic              func,
	input  logic              found,
	input  logic [47:0]       station_addr,
	input  logic signed [7:0] signal_dbm,
	input  logic [3:0]        radio_channel,
	input  logic [31:0]       now_ms,
	input  logic [31:0]       timeout,
	output ssta_pkg::entry_t  upd,
	output ssta_pkg::eval_t   eval
);

	logic        match;
	logic [31:0] age;

	// Address compare; only the first matching entry of an observation counts.
	assign match = (func == ssta_pkg::FUNC_OBS) && !found && (entry.addr == station_addr);

	// Refresh on a hit, with the hit count saturating.
	always_comb begin
		upd = entry;
		if (match) begin
			upd.signal    = signal_dbm;
			upd.channel   = radio_channel;
			upd.last_seen = now_ms;
			upd.active    = 1'b1;
			if (entry.hits != ssta_pkg::HITS_MAX) begin
				upd.hits = entry.hits + 16'd1;
			end
		end
		// Aging: the difference wraps modulo 2^32.
		age = now_ms - upd.last_seen;
		if (age > timeout) begin
			upd.active = 1'b0;
		end
	end

	assign eval.match  = match;
	assign eval.active = upd.active;

endmodule

FILE: hw/rtl/station_sighting_table_with_aging_unit.sv
// Station sighting table with aging. Each beat on obs either records a sighting of a 48-bit
// station address (refreshing a known entry or, if the table has room, appending a new one)
// or only advances time; afterwards every occupied entry older than the stale timeout is
// marked inactive, and one result beat reports the outcome, the slot and hit count touched,
// and the occupied and active entry counts. An item makes one read and write-back of the
// entry memory per occupied slot through a single shared compare-and-age unit, then a finish
// step that inserts and reports once the result register is free. obs is not ready while an
// item is in work; a result that waits to be taken does not hold back the next item's scan.
// The user must write the stale timeout through cfg only while the block is idle (not enforced).
module station_sighting_table_with_aging_unit #(
	parameter int TABLE_DEPTH = ssta_pkg::TABLE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	ssta_obs_if.sink        obs,
	ssta_res_if.source      res,
	ssta_cfg_if.sink        cfg
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int EW    = $bits(ssta_pkg::entry_t);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]        state_q;
	logic [31:0]       timeout_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  act_q;
	logic              proc_s1;
	logic [AW-1:0]     proc_idx_s1;
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic [15:0]       hit_hits_q;

	logic              func_q;
	logic [47:0]       addr_q;
	logic signed [7:0] sig_q;
	logic [3:0]        chan_q;
	logic [1:0]        meth_q;
	logic [31:0]       now_q;

	logic              out_valid_q;
	logic [1:0]        outcome_q;
	logic [5:0]        slot_q;
	logic [15:0]       hits_q;
	logic [6:0]        used_out_q;
	logic [6:0]        active_out_q;

	logic              obs_fire;
	logic              out_free;
	logic              finish_go;
	logic              do_insert;
	logic              issue_more;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;
	logic [EW-1:0]     ram_rdata;
	ssta_pkg::entry_t  rd_entry;
	ssta_pkg::entry_t  upd_entry;
	ssta_pkg::entry_t  new_entry;
	ssta_pkg::eval_t   eval;

	// Handshakes.
	assign obs.ready  = (state_q == ST_IDLE);
	assign obs_fire   = obs.valid && obs.ready;
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || res.ready;
	assign finish_go  = (state_q == ST_FINISH) && out_free;
	assign issue_more = (issue_q < used_q);
	assign do_insert  = finish_go && (func_q == ssta_pkg::FUNC_OBS) && !hit_q &&
		(used_q != CNT_W'(TABLE_DEPTH));

	// Entry appended on a miss; it is fresh, so it is active.
	always_comb begin
		new_entry            = '0;
		new_entry.addr       = addr_q;
		new_entry.first_seen = now_q;
		new_entry.last_seen  = now_q;
		new_entry.hits       = 16'd1;
		new_entry.signal     = sig_q;
		new_entry.channel    = chan_q;
		new_entry.method     = meth_q;
		new_entry.active     = 1'b1;
	end

	// Entry memory: write-back during the scan, append at the end.
	assign rd_entry  = ram_rdata;
	assign ram_we    = proc_s1 || do_insert;
	assign ram_waddr = proc_s1 ? proc_idx_s1 : used_q[AW-1:0];
	assign ram_wdata = proc_s1 ? upd_entry : new_entry;

	ssta_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (issue_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shared compare, refresh and aging unit.
	ssta_entry_unit u_entry (
		.entry         (rd_entry),
		.func          (func_q),
		.found         (hit_q),
		.station_addr  (addr_q),
		.signal_dbm    (sig_q),
		.radio_channel (chan_q),
		.now_ms        (now_q),
		.timeout       (timeout_q),
		.upd           (upd_entry),
		.eval          (eval)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ssta_pkg::TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			timeout_q <= cfg.data;
		end
	end

	// Item fields, held for the whole item.
	always_ff @(posedge clk) begin
		if (obs_fire) begin
			func_q <= obs.func;
			addr_q <= obs.station_addr;
			sig_q  <= obs.signal_dbm;
			chan_q <= obs.radio_channel;
			meth_q <= obs.match_method;
			now_q  <= obs.now_ms;
		end
	end

	// Sequencer: scan the occupied slots, then insert and report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			issue_q     <= '0;
			act_q       <= '0;
			proc_s1     <= 1'b0;
			proc_idx_s1 <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_hits_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (obs_fire) begin
						issue_q <= '0;
						act_q   <= '0;
						hit_q   <= 1'b0;
						proc_s1 <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_more) begin
						proc_s1     <= 1'b1;
						proc_idx_s1 <= issue_q[AW-1:0];
						issue_q     <= issue_q + CNT_W'(1);
					end else begin
						// The last entry, if any, is evaluated in this cycle.
						proc_s1 <= 1'b0;
						state_q <= ST_FINISH;
					end
					// Result of the entry read in the previous cycle.
					if (proc_s1) begin
						if (eval.match) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= proc_idx_s1;
							hit_hits_q <= upd_entry.hits;
						end
						if (eval.active) begin
							act_q <= act_q + CNT_W'(1);
						end
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						if (do_insert) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			used_out_q   <= 7'(do_insert ? used_q + CNT_W'(1) : used_q);
			active_out_q <= 7'(do_insert ? act_q + CNT_W'(1) : act_q);
			if (func_q == ssta_pkg::FUNC_SWEEP) begin
				outcome_q <= ssta_pkg::OUT_SWEEP;
				slot_q    <= '0;
				hits_q    <= '0;
			end else if (hit_q) begin
				outcome_q <= ssta_pkg::OUT_UPDATE;
				slot_q    <= 6'(hit_idx_q);
				hits_q    <= hit_hits_q;
			end else if (do_insert) begin
				outcome_q <= ssta_pkg::OUT_INSERT;
				slot_q    <= 6'(used_q);
				hits_q    <= 16'd1;
			end else begin
				outcome_q <= ssta_pkg::OUT_DROP;
				slot_q    <= '0;
				hits_q    <= '0;
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.outcome        = outcome_q;
	assign res.slot           = slot_q;
	assign res.hits           = hits_q;
	assign res.entries_used   = used_out_q;
	assign res.entries_active = active_out_q;

	// The fill count never passes the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table size");

	// The active count of a scan never exceeds the occupied entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (act_q <= used_q))
		else $error("active count above fill count");

	// A sweep never finds a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_q && (state_q != ST_IDLE) |-> (func_q == ssta_pkg::FUNC_OBS))
		else $error("hit recorded on a sweep");

	// Memory writes stay within the occupied slots or append at the fill count.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= used_q))
		else $error("entry write beyond fill count");

endmodule

FILE: verif/ssta_sighting_checker.sv
`timescale 1ns / 100ps

module ssta_sighting_checker
	import ssta_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ssta_obs_if  obs,
	ssta_res_if  res,
	ssta_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding,
	output int   updates_seen,
	output int   inserts_seen,
	output int   drops_seen,
	output int   sweeps_seen,
	output logic hits_capped
);

	// One predicted result beat.
	typedef struct packed {
		logic [1:0]  outcome;
		logic [5:0]  slot;
		logic [15:0] hits;
		logic [6:0]  used;
		logic [6:0]  active;
	} sighting_report_t;

	// Shadow copy of the sighting table and the stale timeout.
	entry_t           sightings [TABLE_DEPTH];
	int               occupied;
	logic [31:0]      stale_limit;
	sighting_report_t pending_reports [$];

	// Applies one observation or sweep to the shadow table and returns the expected result.
	function automatic sighting_report_t record_sighting(input logic func,
			input logic [47:0] addr, input logic signed [7:0] sig, input logic [3:0] chan,
			input logic [1:0] meth, input logic [31:0] now);
		sighting_report_t rep;
		int               found;
		int               live;
		logic [31:0]      age;
		rep = '{outcome: OUT_SWEEP, slot: '0, hits: '0, used: '0, active: '0};
		found = -1;
		live = 0;
		if (func == FUNC_OBS) begin
			// The lowest occupied slot holding the address is the hit.
			for (int i = 0; i < occupied; i++) begin
				if (found < 0 && sightings[i].addr == addr)
					found = i;
			end
			if (found >= 0) begin
				// The stored method and first-seen time stay as they were.
				sightings[found].signal = sig;
				sightings[found].channel = chan;
				sightings[found].last_seen = now;
				if (sightings[found].hits != HITS_MAX)
					sightings[found].hits++;
				sightings[found].active = 1'b1;
				rep.outcome = OUT_UPDATE;
				rep.slot = 6'(found);
				rep.hits = sightings[found].hits;
			end else if (occupied < TABLE_DEPTH) begin
				sightings[occupied] = '{addr: addr, first_seen: now, last_seen: now,
					hits: 16'd1, signal: sig, channel: chan, method: meth, active: 1'b1};
				rep.outcome = OUT_INSERT;
				rep.slot = 6'(occupied);
				rep.hits = 16'd1;
				occupied++;
			end else begin
				rep.outcome = OUT_DROP;
			end
		end
		// Aging runs after every item; the age wraps with the millisecond clock.
		for (int i = 0; i < occupied; i++) begin
			age = now - sightings[i].last_seen;
			if (age > stale_limit)
				sightings[i].active = 1'b0;
			if (sightings[i].active)
				live++;
		end
		rep.used = 7'(occupied);
		rep.active = 7'(live);
		return rep;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] want,
			input logic [47:0] got);
		$display("[%0t] mismatch in %s: expected %0h, got %0h", $time, what, want, got);
		fail_count++;
	endtask

	// Compares one accepted result beat with the oldest prediction.
	task automatic check_report();
		sighting_report_t want;
		if (pending_reports.size() == 0) begin
			report_mismatch("result beat with nothing pending, outcome", '0,
				48'(res.outcome));
			return;
		end
		want = pending_reports.pop_front();
		if (res.outcome !== want.outcome)
			report_mismatch("outcome", 48'(want.outcome), 48'(res.outcome));
		if (res.slot !== want.slot)
			report_mismatch("slot", 48'(want.slot), 48'(res.slot));
		if (res.hits !== want.hits)
			report_mismatch("hits", 48'(want.hits), 48'(res.hits));
		if (res.entries_used !== want.used)
			report_mismatch("entries_used", 48'(want.used), 48'(res.entries_used));
		if (res.entries_active !== want.active)
			report_mismatch("entries_active", 48'(want.active), 48'(res.entries_active));
		case (want.outcome)
			OUT_UPDATE: updates_seen++;
			OUT_INSERT: inserts_seen++;
			OUT_DROP:   drops_seen++;
			default:    sweeps_seen++;
		endcase
		if (want.outcome == OUT_UPDATE && want.hits == HITS_MAX)
			hits_capped = 1'b1;
	endtask

	// Results are checked before the new item is predicted; a result never belongs to the
	// item accepted on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				sightings[i] = '0;
			occupied = 0;
			stale_limit = TIMEOUT_RST;
			pending_reports.delete();
			fail_count = 0;
			updates_seen = 0;
			inserts_seen = 0;
			drops_seen = 0;
			sweeps_seen = 0;
			hits_capped = 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				stale_limit = cfg.data;
			if (res.valid && res.ready)
				check_report();
			if (obs.valid && obs.ready)
				pending_reports.push_back(record_sighting(obs.func, obs.station_addr,
					obs.signal_dbm, obs.radio_channel, obs.match_method, obs.now_ms));
		end
		outstanding = pending_reports.size();
	end

endmodule

FILE: verif/tb_station_sighting_table_with_aging_unit.sv
`timescale 1ns / 100ps

module tb_station_sighting_table_with_aging_unit;
	import ssta_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASES       = 6;
	localparam int POOL_SIZE    = 80;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_LONG} stall_mode_t;

	logic clk;
	logic arst_n;

	ssta_obs_if obs ();
	ssta_res_if res ();
	ssta_cfg_if cfg ();

	int   fail_count;
	int   outstanding;
	int   updates_seen;
	int   inserts_seen;
	int   drops_seen;
	int   sweeps_seen;
	logic hits_capped;

	logic        gaps_en;
	logic        stall_en;
	int          burst_left;
	int          cycle_count = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_seg = 0;
	int          stall_run = 0;
	logic [47:0] addr_pool [POOL_SIZE];
	logic [31:0] clock_ms;

	station_sighting_table_with_aging_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.obs    (obs),
		.res    (res),
		.cfg    (cfg)
	);

	ssta_sighting_checker u_sighting_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.obs          (obs),
		.res          (res),
		.cfg          (cfg),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.updates_seen (updates_seen),
		.inserts_seen (inserts_seen),
		.drops_seen   (drops_seen),
		.sweeps_seen  (sweeps_seen),
		.hits_capped  (hits_capped)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// Watchdog on the total run length.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Run stopped after %0d cycles with %0d results pending", cycle_count,
			outstanding);
		$display("TEST FAILED");
		$finish;
	end

	// Result receiver: segments of free flow, coin-flip ready and long stalls.
	always @(negedge clk) begin
		if (!stall_en) begin
			res.ready = 1'b1;
		end else begin
			if (stall_seg == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				stall_seg = $urandom_range(20, 300);
				stall_run = 0;
			end
			stall_seg--;
			case (stall_mode)
				STALL_NONE: res.ready = 1'b1;
				STALL_COIN: res.ready = $urandom_range(0, 1);
				default: begin
					// Ready is held low for a while, then opened for a short window.
					if (stall_run == 0) begin
						res.ready = !res.ready;
						stall_run = res.ready ? $urandom_range(1, 4) : $urandom_range(1, 12);
					end
					stall_run--;
				end
			endcase
		end
	end

	// Sends one item; between bursts the valid line drops for a random gap.
	task automatic send_item(input logic func, input logic [47:0] addr,
			input logic signed [7:0] sig, input logic [3:0] chan, input logic [1:0] meth,
			input logic [31:0] now);
		int gap;
		if (gaps_en && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			@(negedge clk);
			obs.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		obs.valid = 1'b1;
		obs.func = func;
		obs.station_addr = addr;
		obs.signal_dbm = sig;
		obs.radio_channel = chan;
		obs.match_method = meth;
		obs.now_ms = now;
		do @(posedge clk); while (!obs.ready);
	endtask

	// Holds the sender off until every pending result has been taken.
	task automatic drain();
		@(negedge clk);
		obs.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] value);
		drain();
		cfg.valid = 1'b1;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	initial begin
		logic [31:0] phase_timeout [PHASES];
		logic [47:0] addr;
		int          pick;
		int          step;

		arst_n = 1'b0;
		obs.valid = 1'b0;
		obs.func = FUNC_OBS;
		obs.station_addr = '0;
		obs.signal_dbm = '0;
		obs.radio_channel = '0;
		obs.match_method = '0;
		obs.now_ms = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		gaps_en = 1'b0;
		stall_en = 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a sweep on the empty table, then field extremes on the first slot.
		send_item(FUNC_SWEEP, 48'hFFFF_FFFF_FFFF, 8'sh7F, 4'd15, 2'd3, 32'd0);
		send_item(FUNC_OBS, 48'h0, 8'sh80, 4'd0, 2'd0, 32'd0);

		// A few more hits on the first entry raise its count.
		repeat (3)
			send_item(FUNC_OBS, 48'h0, 8'($urandom), 4'($urandom), 2'($urandom), 32'd0);

		// Second entry at the far end of time; the first one goes stale.
		send_item(FUNC_OBS, 48'hFFFF_FFFF_FFFF, 8'sh7F, 4'd15, 2'd3, 32'hFFFF_FFFF);
		// A hit with a different method leaves the stored method alone.
		send_item(FUNC_OBS, 48'h0, 8'sh00, 4'd14, 2'd2, 32'hFFFF_FFFF);
		// The clock wraps; the age is taken modulo 2^32.
		send_item(FUNC_OBS, 48'hFFFF_FFFF_FFFF, -8'sd60, 4'd1, 2'd1, 32'd100);
		// Exactly at the timeout an entry stays active, one past it goes stale.
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'd30100);
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'd30101);
		// Addresses one bit away from stored ones are new stations.
		send_item(FUNC_OBS, 48'h8000_0000_0000, 8'sh01, 4'd1, 2'd1, 32'd30101);
		send_item(FUNC_OBS, 48'h0000_0000_0001, 8'shFF, 4'd14, 2'd2, 32'd30102);
		send_item(FUNC_OBS, 48'h7FFF_FFFF_FFFF, 8'sh55, 4'd7, 2'd3, 32'd30103);
		send_item(FUNC_OBS, 48'hFFFF_FFFF_FFFE, 8'shAA, 4'd8, 2'd0, 32'd30104);
		send_item(FUNC_OBS, 48'h8000_0000_0000, -8'sd90, 4'd6, 2'd0, 32'd30500);

		// Zero timeout: anything not seen in this very millisecond is stale.
		write_timeout(32'd0);
		send_item(FUNC_OBS, 48'h0000_0000_0001, 8'sh10, 4'd3, 2'd1, 32'd40000);
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'd40000);
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'd40001);

		// Largest timeout: nothing can go stale, even across a full wrap.
		write_timeout(32'hFFFF_FFFF);
		send_item(FUNC_OBS, 48'h7FFF_FFFF_FFFF, 8'sh20, 4'd2, 2'd2, 32'd7);
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'd6);
		send_item(FUNC_SWEEP, 48'h0, 8'sh00, 4'd0, 2'd0, 32'h8000_0000);

		// Station pool for the random part; more stations than the table holds.
		addr_pool[0] = 48'h0;
		addr_pool[1] = 48'hFFFF_FFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = {16'($urandom), 32'($urandom)};

		phase_timeout[0] = TIMEOUT_RST;
		phase_timeout[1] = 32'd500;
		phase_timeout[2] = 32'hFFFF_FFFF;
		phase_timeout[3] = 32'($urandom_range(1, 100000));
		phase_timeout[4] = 32'd0;
		phase_timeout[5] = 32'($urandom);
		clock_ms = 32'hFFF0_0000;

		for (int p = 0; p < PHASES; p++) begin
			write_timeout(phase_timeout[p]);
			gaps_en = (p != 2);
			stall_en = (p != 2);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				// Time mostly creeps forward, with long silences and jumps anywhere.
				pick = $urandom_range(0, 9);
				if (pick < 7)
					step = $urandom_range(0, 2000);
				else if (pick == 7)
					step = $urandom_range(20000, 60000);
				else if (pick == 8)
					step = $urandom;
				else
					step = 0;
				clock_ms += 32'(step);

				// Mostly known stations, some fresh ones and near misses.
				pick = $urandom_range(0, 9);
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
				if (pick == 8)
					addr = {16'($urandom), 32'($urandom)};
				else if (pick == 9)
					addr = addr ^ (48'd1 << $urandom_range(0, 47));

				send_item(($urandom_range(0, 7) == 0) ? FUNC_SWEEP : FUNC_OBS, addr,
					8'($urandom), 4'($urandom), 2'($urandom), clock_ms);

				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		drain();
		repeat (80) @(negedge clk);

		$display("Covered %0d results: %0d updates, %0d inserts, %0d drops, %0d sweeps.",
			updates_seen + inserts_seen + drops_seen + sweeps_seen, updates_seen,
			inserts_seen, drops_seen, sweeps_seen);
		$display("Timeouts from zero to all ones were used; hit ceiling reached: %0d.",
			hits_capped);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
